[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/tbga_pkg.sv]
// Shared constants, operation codes and types for the track bitmap allocator.
// No dependencies.
`default_nettype none

package tbga_pkg;

  localparam int MAX_TRACKS    = 256;
  localparam int TRACK_W       = $clog2(MAX_TRACKS);
  localparam int TRACK_FIELD_W = 8;
  localparam int WORD_W        = 16;
  localparam int GROUP_W       = 12;
  localparam int POS_W         = 4;
  localparam int CNT_W         = POS_W + 1;
  localparam int SPT_W         = 5;
  localparam int BASE_W        = GROUP_W + 1;
  localparam int OP_W          = 3;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int DIV_STEPS     = GROUP_W;

  localparam logic [SPT_W-1:0] SPT_MIN = SPT_W'(1);
  localparam logic [SPT_W-1:0] SPT_MAX = SPT_W'(WORD_W);

  localparam logic [TRACK_FIELD_W:0] LOAD_LIMIT  = (TRACK_FIELD_W + 1)'(MAX_TRACKS);
  localparam logic [BASE_W-1:0]      QUOT_LIMIT  = BASE_W'(MAX_TRACKS);
  localparam logic [TRACK_W:0]       TRACK_END   = (TRACK_W + 1)'(MAX_TRACKS);

  localparam logic [OP_W-1:0] OP_MARK_USED = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST      = 3'd2;
  localparam logic [OP_W-1:0] OP_FIRST     = 3'd3;
  localparam logic [OP_W-1:0] OP_RUN       = 3'd4;
  localparam logic [OP_W-1:0] OP_LOAD      = 3'd5;

  localparam logic [1:0] REG_SPT  = 2'd0;
  localparam logic [1:0] REG_LAST = 2'd1;
  localparam logic [1:0] REG_INV  = 2'd2;

  typedef struct packed {
    logic               done;
    logic [GROUP_W-1:0] quot;
    logic [POS_W-1:0]   rem;
  } div_res_t;

  typedef struct packed {
    logic             any_free;
    logic             all_free;
    logic [POS_W-1:0] first_pos;
    logic [CNT_W-1:0] lead_cnt;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/core/tbga_map_ram.sv]
// Map word memory: one word per track, one write and one registered read port.
// Depends on tbga_pkg.
`default_nettype none

module tbga_map_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [tbga_pkg::TRACK_W-1:0] waddr,
  input  wire logic [tbga_pkg::WORD_W-1:0]  wdata,
  input  wire logic [tbga_pkg::TRACK_W-1:0] raddr,
  output logic      [tbga_pkg::WORD_W-1:0]  rdata
);

  logic [tbga_pkg::WORD_W-1:0] mem [tbga_pkg::MAX_TRACKS];
  logic [tbga_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/tbga_divider.sv]
// Restoring divider, one quotient bit per cycle: group / groups-per-track.
// Depends on tbga_pkg.
`default_nettype none

module tbga_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tbga_pkg::GROUP_W-1:0] dividend,
  input  wire logic [tbga_pkg::SPT_W-1:0]   divisor,
  output tbga_pkg::div_res_t                res
);

  localparam int GW = tbga_pkg::GROUP_W;
  localparam int PW = tbga_pkg::POS_W;
  localparam int SW = tbga_pkg::SPT_W;
  localparam int CW = $clog2(tbga_pkg::DIV_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(tbga_pkg::DIV_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [GW-1:0] quot_r, quot_nxt;
  logic [SW-1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    // shifted partial remainder; remainder stays below the divisor (<= 16)
    trial    = {rem_r, quot_r[GW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quot_nxt = dividend;
    end else if (busy_r) begin
      if (trial >= divisor) begin
        rem_nxt  = PW'(trial - divisor);
        quot_nxt = {quot_r[GW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[PW-1:0];
        quot_nxt = {quot_r[GW-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/tbga_word_eval.sv]
// Evaluates one map word during a search: free mask, first free position,
// length of the leading free run. Depends on tbga_pkg.
`default_nettype none

module tbga_word_eval (
  input  wire logic [tbga_pkg::WORD_W-1:0] word,
  input  wire logic                        inv,
  input  wire logic [tbga_pkg::SPT_W-1:0]  spt,
  input  wire logic [tbga_pkg::BASE_W-1:0] lim,
  output tbga_pkg::scan_res_t              res
);

  localparam int WW = tbga_pkg::WORD_W;
  localparam int PW = tbga_pkg::POS_W;

  logic [WW-1:0] free_w;
  logic [WW-1:0] valid_w;
  logic [WW-1:0] hit_w;
  logic          run_on;

  always_comb begin
    free_w = word ^ {WW{inv}};
    // position p sits at bit WW-1-p; it counts if inside the track and the disk
    for (int p = 0; p < WW; p++) begin
      valid_w[WW-1-p] = (p < int'(spt)) && (p <= int'(lim));
    end
    hit_w        = free_w & valid_w;
    res.any_free = |hit_w;
    res.all_free = (hit_w == valid_w);
    res.first_pos = '0;
    for (int p = WW - 1; p >= 0; p--) begin
      if (hit_w[WW-1-p]) begin
        res.first_pos = PW'(p);
      end
    end
    run_on       = 1'b1;
    res.lead_cnt = '0;
    for (int p = 0; p < WW; p++) begin
      run_on = run_on & hit_w[WW-1-p];
      if (run_on) begin
        res.lead_cnt = res.lead_cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/track_bitmap_group_allocator.sv]
// Track bitmap group allocator: control sequencer, config registers, map memory.
// Depends on tbga_pkg, tbga_map_ram, tbga_divider, tbga_word_eval, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   mark used, mark free, test, first free, free run, load map word. Every
//   transaction yields exactly one result transaction on out_valid/out_ready.
//   Config registers sit on the APB-style port (groups per track at 0x0, last
//   group at 0x4, inversion at 0x8); write them only while the block is idle.
//   Steps from the accepting edge to out_valid:
//     load word, unknown op, zero-length run: output register
//     mark and test: 12 divider steps, memory read, modify/write-back,
//       output register
//     searches: a scan step for each map word scanned, another when the scan
//       runs off the end, then the output register; at most MAX_TRACKS words
//   One transaction is in flight at a time; the next one can be accepted from
//   the first cycle in which out_valid is high, even if the result is not taken yet.
//   If the receiver stalls, the finished result of the following transaction
//   waits until the output register frees up, and the input stalls with it.
//   Reset clears control state and config to defaults; map words are
//   undefined until loaded. No clearing pass.
`default_nettype none

`include "assert_macros.svh"

module track_bitmap_group_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tbga_pkg::OP_W-1:0]           in_operation,
  input  wire logic [tbga_pkg::GROUP_W-1:0]        in_group,
  input  wire logic [tbga_pkg::GROUP_W-1:0]        in_run_length,
  input  wire logic [tbga_pkg::TRACK_FIELD_W-1:0]  in_track,
  input  wire logic [tbga_pkg::WORD_W-1:0]         in_map_word,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_group_used,
  output logic                                     out_found,
  output logic      [tbga_pkg::GROUP_W-1:0]        out_found_group,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tbga_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [tbga_pkg::DATA_W-1:0]         pwdata,
  output logic      [tbga_pkg::DATA_W-1:0]         prdata,
  output logic                                     pready
);

  localparam int GW = tbga_pkg::GROUP_W;
  localparam int TW = tbga_pkg::TRACK_W;
  localparam int BW = tbga_pkg::BASE_W;
  localparam int SW = tbga_pkg::SPT_W;
  localparam int WW = tbga_pkg::WORD_W;
  localparam int DW = tbga_pkg::DATA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // config registers
  logic [SW-1:0] spt_r;
  logic [GW-1:0] last_group_r;
  logic          inv_r;
  logic [SW-1:0] spt_eff;

  // sequencer
  logic [2:0]                  state_r, state_nxt;
  logic [tbga_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [GW-1:0]               group_r, group_nxt;
  logic [GW-1:0]               want_r, want_nxt;
  logic [GW-1:0]               cnt_r, cnt_nxt;
  logic [GW-1:0]               start_r, start_nxt;
  logic [TW:0]                 ev_trk_r, ev_trk_nxt;
  logic [BW-1:0]               base_r, base_nxt;
  logic                        res_used_r, res_used_nxt;
  logic                        res_found_r, res_found_nxt;
  logic [GW-1:0]               res_fg_r, res_fg_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_used_r, out_used_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [GW-1:0]               out_fg_r, out_fg_nxt;

  // datapath
  logic                        in_fire;
  logic                        div_start;
  tbga_pkg::div_res_t          div_res;
  tbga_pkg::scan_res_t         scan_res;
  logic                        ram_we;
  logic [TW-1:0]               ram_waddr;
  logic [WW-1:0]               ram_wdata;
  logic [TW-1:0]               ram_raddr;
  logic [WW-1:0]               ram_rdata;
  logic [TW:0]                 trk_inc;
  logic [BW-1:0]               lim;
  logic [BW-1:0]               run_sum;
  logic                        in_range;
  logic                        in_map;
  logic                        bit_free;
  logic                        scan_end;
  logic [WW-1:0]               word_mod;

  // ---------------- config port ----------------
  always_comb begin
    priority if (spt_r == '0) begin
      spt_eff = tbga_pkg::SPT_MIN;
    end else if (spt_r > tbga_pkg::SPT_MAX) begin
      spt_eff = tbga_pkg::SPT_MAX;
    end else begin
      spt_eff = spt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r        <= tbga_pkg::SPT_MAX;
      last_group_r <= '1;
      inv_r        <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        tbga_pkg::REG_SPT:  spt_r        <= pwdata[SW-1:0];
        tbga_pkg::REG_LAST: last_group_r <= pwdata[GW-1:0];
        tbga_pkg::REG_INV:  inv_r        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tbga_pkg::REG_SPT:  prdata = DW'(spt_r);
      tbga_pkg::REG_LAST: prdata = DW'(last_group_r);
      tbga_pkg::REG_INV:  prdata = DW'(inv_r);
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- submodules ----------------
  tbga_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tbga_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_group),
    .divisor  (spt_eff),
    .res      (div_res)
  );

  tbga_word_eval u_eval (
    .word (ram_rdata),
    .inv  (inv_r),
    .spt  (spt_eff),
    .lim  (lim),
    .res  (scan_res)
  );

  // ---------------- sequencer ----------------
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign trk_inc  = ev_trk_r + 1'b1;
  assign lim      = {1'b0, last_group_r} - base_r;
  assign scan_end = (base_r > {1'b0, last_group_r}) || (ev_trk_r == tbga_pkg::TRACK_END);
  assign run_sum  = {1'b0, cnt_r} + BW'(scan_res.lead_cnt);
  assign in_range = (group_r <= last_group_r);
  assign in_map   = ({1'b0, div_res.quot} < tbga_pkg::QUOT_LIMIT);
  assign bit_free = ram_rdata[~div_res.rem] ^ inv_r;

  always_comb begin
    word_mod = ram_rdata;
    word_mod[~div_res.rem] = (op_r == tbga_pkg::OP_MARK_FREE) ^ inv_r;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    group_nxt     = group_r;
    want_nxt      = want_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    ev_trk_nxt    = ev_trk_r;
    base_nxt      = base_r;
    res_used_nxt  = res_used_r;
    res_found_nxt = res_found_r;
    res_fg_nxt    = res_fg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_used_nxt  = out_used_r;
    out_found_nxt = out_found_r;
    out_fg_nxt    = out_fg_r;
    ram_we        = 1'b0;
    ram_waddr     = in_track[TW-1:0];
    ram_wdata     = in_map_word;
    ram_raddr     = '0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // raddr stays at track 0 so a search has its first word next cycle
        if (in_fire) begin
          op_nxt        = in_operation;
          group_nxt     = in_group;
          want_nxt      = in_run_length;
          cnt_nxt       = '0;
          start_nxt     = '0;
          ev_trk_nxt    = '0;
          base_nxt      = '0;
          res_used_nxt  = 1'b0;
          res_found_nxt = 1'b0;
          res_fg_nxt    = '0;
          unique case (in_operation)
            tbga_pkg::OP_LOAD: begin
              ram_we    = ({1'b0, in_track} < tbga_pkg::LOAD_LIMIT);
              state_nxt = ST_DONE;
            end
            tbga_pkg::OP_MARK_USED,
            tbga_pkg::OP_MARK_FREE,
            tbga_pkg::OP_TEST: begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
            tbga_pkg::OP_FIRST: begin
              state_nxt = ST_SCAN;
            end
            tbga_pkg::OP_RUN: begin
              state_nxt = (in_run_length == '0) ? ST_DONE : ST_SCAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_DIV: begin
        ram_raddr = div_res.quot[TW-1:0];
        if (div_res.done) begin
          state_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        ram_raddr = div_res.quot[TW-1:0];
        ram_waddr = div_res.quot[TW-1:0];
        ram_wdata = word_mod;
        if (op_r == tbga_pkg::OP_TEST) begin
          res_used_nxt = in_range && (!in_map || !bit_free);
        end else begin
          ram_we = in_range && in_map;
        end
        state_nxt = ST_DONE;
      end

      ST_SCAN: begin
        // prefetch the next word while this one is evaluated
        ram_raddr = trk_inc[TW-1:0];
        if (scan_end) begin
          state_nxt = ST_DONE;
        end else if (op_r == tbga_pkg::OP_FIRST) begin
          if (scan_res.any_free) begin
            res_found_nxt = 1'b1;
            res_fg_nxt    = GW'(base_r + BW'(scan_res.first_pos));
            state_nxt     = ST_DONE;
          end else begin
            ev_trk_nxt = trk_inc;
            base_nxt   = base_r + BW'(spt_eff);
          end
        end else begin
          if (run_sum >= {1'b0, want_r}) begin
            res_found_nxt = 1'b1;
            res_fg_nxt    = (cnt_r == '0) ? base_r[GW-1:0] : start_r;
            state_nxt     = ST_DONE;
          end else begin
            // a used group drops the run; the search resumes at the next track
            if (scan_res.all_free) begin
              cnt_nxt = run_sum[GW-1:0];
              if (cnt_r == '0) begin
                start_nxt = base_r[GW-1:0];
              end
            end else begin
              cnt_nxt = '0;
            end
            ev_trk_nxt = trk_inc;
            base_nxt   = base_r + BW'(spt_eff);
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_used_nxt  = res_used_r;
          out_found_nxt = res_found_r;
          out_fg_nxt    = res_fg_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    group_r     <= group_nxt;
    want_r      <= want_nxt;
    cnt_r       <= cnt_nxt;
    start_r     <= start_nxt;
    ev_trk_r    <= ev_trk_nxt;
    base_r      <= base_nxt;
    res_used_r  <= res_used_nxt;
    res_found_r <= res_found_nxt;
    res_fg_r    <= res_fg_nxt;
    out_used_r  <= out_used_nxt;
    out_found_r <= out_found_nxt;
    out_fg_r    <= out_fg_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_group_used  = out_used_r;
  assign out_found       = out_found_r;
  assign out_found_group = out_fg_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_we_state, ram_we, (state_r == ST_IDLE) || (state_r == ST_ACC), "stray map write")
  `ASSERT_IMPL(a_div_state, div_res.done, state_r == ST_DIV, "divider done outside DIV")
  `ASSERT_ALWAYS(a_used_found, !(out_valid_r && out_used_r && out_found_r), "used and found set")

endmodule

`default_nettype wire
